// ----- design/vda_pkg.sv -----
// Package for vector_direction_angle: widths, angle constants and the arctangent table.
package vda_pkg;

  localparam int COORD_WIDTH          = 16;
  localparam int CORDIC_STAGES        = 16;
  localparam int DEGREE_FRACTION_BITS = 7;

  // Coordinate difference, CORDIC datapath, Q30 angle and wrapped-angle widths
  localparam int D_W  = COORD_WIDTH + 1;
  localparam int X_W  = D_W + CORDIC_STAGES + 3;
  localparam int Z_W  = 35;
  localparam int ZU_W = 33;
  localparam int K_W  = 30;
  localparam int DEG_W = 24;

  localparam int ATAN_LEN = 24;

  localparam logic signed [Z_W-1:0] PI_Q30      = 35'sd3373259426;
  localparam logic signed [Z_W-1:0] HALF_PI_Q30 = 35'sd1686629713;
  localparam logic signed [Z_W-1:0] TWO_PI_Q30  = 35'sd6746518852;

  // 360 / (2*pi) in Q24
  localparam logic [K_W-1:0] DEG_PER_RAD_Q24 = 30'd961263669;
  localparam int             FULL_TURN_DEG   = 360;
  localparam int             DEG_SH          = 54 - DEGREE_FRACTION_BITS;
  localparam logic [DEG_W-1:0] DEG_LIMIT     = DEG_W'(FULL_TURN_DEG << DEGREE_FRACTION_BITS);

  // Radians rounding: Q30 to Q13
  localparam int RAD_SH = 17;

  // atan(2^-i) in Q30, rounded
  function automatic logic signed [Z_W-1:0] atan_q30(input int i);
    logic signed [Z_W-1:0] v;
    case (i)
      0:       v = 35'sd843314857;
      1:       v = 35'sd497837829;
      2:       v = 35'sd263043837;
      3:       v = 35'sd133525159;
      4:       v = 35'sd67021687;
      5:       v = 35'sd33543516;
      6:       v = 35'sd16775851;
      7:       v = 35'sd8388437;
      8:       v = 35'sd4194283;
      9:       v = 35'sd2097149;
      10:      v = 35'sd1048576;
      11:      v = 35'sd524288;
      12:      v = 35'sd262144;
      13:      v = 35'sd131072;
      14:      v = 35'sd65536;
      15:      v = 35'sd32768;
      16:      v = 35'sd16384;
      17:      v = 35'sd8192;
      18:      v = 35'sd4096;
      19:      v = 35'sd2048;
      20:      v = 35'sd1024;
      21:      v = 35'sd512;
      22:      v = 35'sd256;
      23:      v = 35'sd128;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

// ----- design/vector_direction_angle.sv -----
// Pipelined CORDIC atan2 of the vector between two points: radians, degrees, whole degrees.
//
//  channel | ports                                         | handshake
//  --------+-----------------------------------------------+------------------------------
//  input   | in_first_x/y, in_second_x/y (16b signed Q12.4)| start && !busy at clk edge
//  result  | out_angle_radians, out_angle_degrees,         | out_valid strobe, one cycle
//          | out_whole_degrees                             |
//
// One item per cycle. The pipeline has two input stages,
// one stage per CORDIC micro-rotation, then clamp, wrap, two-part degree multiply,
// degree rounding and final wrap. The multiply by 360/(2*pi) is split in two
// partial products over one stage. busy stays low: the pipeline never stalls.
// Synchronous active-low reset clears the valid bits only; the receiver cannot stall.
module vector_direction_angle
  import vda_pkg::*;
(
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic signed [COORD_WIDTH-1:0] in_first_x,
  input  logic signed [COORD_WIDTH-1:0] in_first_y,
  input  logic signed [COORD_WIDTH-1:0] in_second_x,
  input  logic signed [COORD_WIDTH-1:0] in_second_y,
  output logic                          out_valid,
  output logic signed [15:0]            out_angle_radians,
  output logic        [15:0]            out_angle_degrees,
  output logic        [8:0]             out_whole_degrees
);

  localparam int LATENCY = CORDIC_STAGES + 7;

  // axis cases that bypass the CORDIC result
  typedef enum logic [2:0] {
    SP_NONE,
    SP_ZERO,
    SP_PI,
    SP_HPOS,
    SP_HNEG
  } special_t;

  assign busy = 1'b0;

  // ---------------- stage P0: differences
  logic                  p0_v_r;
  logic signed [D_W-1:0] dx_r, dy_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p0_v_r <= 1'b0;
    end else begin
      p0_v_r <= start && !busy;
    end
    dx_r <= D_W'(in_second_x) - D_W'(in_first_x);
    dy_r <= D_W'(in_second_y) - D_W'(in_first_y);
  end

  // ---------------- stage P1: axis detect and half-plane turn
  logic signed [X_W-1:0] dxe, dye, x0_nxt, y0_nxt;
  logic signed [Z_W-1:0] z0_nxt;
  special_t              sp0_nxt;

  always_comb begin
    dxe = X_W'(dx_r);
    dye = X_W'(dy_r);
    if (dx_r < 0) begin
      x0_nxt = (-dxe) <<< CORDIC_STAGES;
      y0_nxt = (-dye) <<< CORDIC_STAGES;
      z0_nxt = (dy_r > 0) ? PI_Q30 : -PI_Q30;
    end else begin
      x0_nxt = dxe <<< CORDIC_STAGES;
      y0_nxt = dye <<< CORDIC_STAGES;
      z0_nxt = '0;
    end
    if (dy_r == 0) begin
      sp0_nxt = (dx_r < 0) ? SP_PI : SP_ZERO;
    end else if (dx_r == 0) begin
      sp0_nxt = (dy_r > 0) ? SP_HPOS : SP_HNEG;
    end else begin
      sp0_nxt = SP_NONE;
    end
  end

  // ---------------- CORDIC vectoring, one micro-rotation per stage
  logic                  cv_r  [0:CORDIC_STAGES];
  logic signed [X_W-1:0] cx_r  [0:CORDIC_STAGES];
  logic signed [X_W-1:0] cy_r  [0:CORDIC_STAGES];
  logic signed [Z_W-1:0] cz_r  [0:CORDIC_STAGES];
  special_t              csp_r [0:CORDIC_STAGES];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i <= CORDIC_STAGES; i++) begin
        cv_r[i] <= 1'b0;
      end
    end else begin
      cv_r[0] <= p0_v_r;
      for (int i = 0; i < CORDIC_STAGES; i++) begin
        cv_r[i+1] <= cv_r[i];
      end
    end
    cx_r[0]  <= x0_nxt;
    cy_r[0]  <= y0_nxt;
    cz_r[0]  <= z0_nxt;
    csp_r[0] <= sp0_nxt;
    for (int i = 0; i < CORDIC_STAGES; i++) begin
      csp_r[i+1] <= csp_r[i];
      if (!cy_r[i][X_W-1]) begin
        cx_r[i+1] <= cx_r[i] + (cy_r[i] >>> i);
        cy_r[i+1] <= cy_r[i] - (cx_r[i] >>> i);
        cz_r[i+1] <= cz_r[i] + atan_q30(i);
      end else begin
        cx_r[i+1] <= cx_r[i] - (cy_r[i] >>> i);
        cy_r[i+1] <= cy_r[i] + (cx_r[i] >>> i);
        cz_r[i+1] <= cz_r[i] - atan_q30(i);
      end
    end
  end

  // ---------------- stage A: axis override and clamp to [-pi, pi]
  logic                  a_v_r;
  logic signed [Z_W-1:0] zc_r, zc_nxt, zsel;

  always_comb begin
    case (csp_r[CORDIC_STAGES])
      SP_ZERO: zsel = '0;
      SP_PI:   zsel = PI_Q30;
      SP_HPOS: zsel = HALF_PI_Q30;
      SP_HNEG: zsel = -HALF_PI_Q30;
      default: zsel = cz_r[CORDIC_STAGES];
    endcase
    if (zsel > PI_Q30) begin
      zc_nxt = PI_Q30;
    end else if (zsel < -PI_Q30) begin
      zc_nxt = -PI_Q30;
    end else begin
      zc_nxt = zsel;
    end
  end

  // ---------------- stage B: radians rounding and wrap to [0, 2*pi)
  logic                  b_v_r;
  logic signed [15:0]    rad_b_r;
  logic        [ZU_W-1:0] zu_r;
  logic signed [Z_W-1:0] rsum, zw;

  always_comb begin
    rsum = (zc_r + Z_W'(65536)) >>> RAD_SH;
    zw   = (zc_r < 0) ? zc_r + TWO_PI_Q30 : zc_r;
  end

  // ---------------- stage C: partial products of the degree scale
  logic                         c_v_r;
  logic signed [15:0]           rad_c_r;
  logic [16+K_W-1:0]            pp_lo_r;
  logic [ZU_W-16+K_W-1:0]       pp_hi_r;

  // ---------------- stage D: sum, round, shift
  logic                   d_v_r;
  logic signed [15:0]     rad_d_r;
  logic [DEG_W-1:0]       deg_raw_r;
  logic [63:0]            psum;

  assign psum = (64'(pp_hi_r) << 16) + 64'(pp_lo_r) + (64'd1 << (DEG_SH - 1));

  // ---------------- stage E: final wrap at a full turn
  logic [DEG_W-1:0] deg_w;

  assign deg_w = (deg_raw_r >= DEG_LIMIT) ? deg_raw_r - DEG_LIMIT : deg_raw_r;

  // valid bits and post-CORDIC payload registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_v_r     <= 1'b0;
      b_v_r     <= 1'b0;
      c_v_r     <= 1'b0;
      d_v_r     <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      a_v_r     <= cv_r[CORDIC_STAGES];
      b_v_r     <= a_v_r;
      c_v_r     <= b_v_r;
      d_v_r     <= c_v_r;
      out_valid <= d_v_r;
    end
    zc_r      <= zc_nxt;
    rad_b_r   <= 16'(rsum);
    zu_r      <= ZU_W'(zw);
    rad_c_r   <= rad_b_r;
    pp_lo_r   <= (16+K_W)'(zu_r[15:0] * DEG_PER_RAD_Q24);
    pp_hi_r   <= (ZU_W-16+K_W)'(zu_r[ZU_W-1:16] * DEG_PER_RAD_Q24);
    rad_d_r   <= rad_c_r;
    deg_raw_r <= DEG_W'(psum >> DEG_SH);
    out_angle_radians <= rad_d_r;
    out_angle_degrees <= 16'(deg_w);
    out_whole_degrees <= 9'(deg_w >> DEGREE_FRACTION_BITS);
  end

  // ---------------- assertions
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##LATENCY out_valid)
    else $error("accepted item did not reach the output after the pipeline latency");

  a_deg_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_angle_degrees < 16'(DEG_LIMIT)))
    else $error("degree output not wrapped below a full turn");

  a_whole_match: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_whole_degrees == 9'(out_angle_degrees >> DEGREE_FRACTION_BITS)))
    else $error("whole degrees disagree with fractional degrees");

  a_rad_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_angle_radians <= 16'sd25736 && out_angle_radians >= -16'sd25736))
    else $error("radian output outside -pi..pi");

endmodule
